>>> hw/rtl/rwat_pkg.sv
// Shared types and constants for the receive window acknowledgement tracker.
// No dependencies; imported by rwat_ram users and the top level.
package rwat_pkg;

  localparam int SLOTS_DEF  = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int SEQ_W      = 8;
  localparam int DATA_W     = 8;
  localparam int NEXT_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] WINDOW_SIZE_RST  = 7'd4;
  localparam logic [CFG_DATA_W-1:0] ACTIVE_SLOTS_RST = 7'd64;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DONE
  } rwat_state_t;

endpackage

>>> hw/rtl/rwat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rwat_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/receive_window_ack_tracker.sv
// Receive window acknowledgement tracker (selective repeat receiver side).
// Depends on rwat_pkg and rwat_ram.
//
// Each input transaction is one arrived segment; each produces exactly one
// result transaction. A zero data byte ends the transfer (finished) and
// returns the window to its start. A sequence number at or beyond the active
// slot count is rejected with no change of state. Any other segment marks its
// slot received, then the received map is scanned from the next expected
// number up to the window's upper bound for the first gap; that gap becomes
// next_seq. With no gap the window is flushed and restarts at zero.
// A scanned segment reads the received map RAM one slot at a time through
// its single read port, visiting at most min(window_size, active_slots)
// slots. A result held by out_ready low stalls the block until it is taken.
// Finish and flush add a clearing pass over every slot of that RAM, and after
// reset the block runs the same pass before in_ready rises.
// Configuration writes are taken at any time; a new window size takes effect
// at the next window move, while a new active slot count applies at once to
// the rejection check and the scan limit.
module receive_window_ack_tracker #(
  parameter int SLOTS = rwat_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [rwat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rwat_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // segment input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rwat_pkg::SEQ_W-1:0]      in_seq_num,
  input  logic [rwat_pkg::DATA_W-1:0]     in_data_byte,
  // acknowledgement result
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rwat_pkg::NEXT_W-1:0]     out_next_seq,
  output logic                            out_window_flushed,
  output logic                            out_finished,
  output logic                            out_seq_rejected
);

  import rwat_pkg::*;

  localparam int IW = $clog2(SLOTS);          // slot index
  localparam int CW = $clog2(SLOTS + 1);      // slot count, 1..SLOTS
  localparam int XW = (CW > SEQ_W) ? CW : SEQ_W;
  localparam int VW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

  // Clamp a register value to 1..SLOTS
  function automatic logic [CW-1:0] clamp_f(input logic [CFG_DATA_W-1:0] v);
    logic [VW-1:0] ve;
    ve = VW'(v);
    if (ve == '0) begin
      clamp_f = CW'(1);
    end else if (ve > VW'(SLOTS)) begin
      clamp_f = CW'(SLOTS);
    end else begin
      clamp_f = ve[CW-1:0];
    end
  endfunction

  // Upper window bound: min(ne - 1 + w, a - 1)
  function automatic logic [IW-1:0] bound_f(input logic [IW-1:0] ne,
                                            input logic [CW-1:0] w,
                                            input logic [CW-1:0] a);
    logic [CW:0] sum;
    logic [CW:0] am1;
    sum = (CW+1)'(ne) + (CW+1)'(w) - (CW+1)'(1);
    am1 = (CW+1)'(a) - (CW+1)'(1);
    if (sum < (CW+1)'(a)) begin
      bound_f = sum[IW-1:0];
    end else begin
      bound_f = am1[IW-1:0];
    end
  endfunction

  rwat_state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] win_r, act_r;
  logic [IW-1:0]         clr_r, clr_nxt;
  logic [SEQ_W-1:0]      seq_r, seq_nxt;
  logic [DATA_W-1:0]     data_r, data_nxt;
  logic [IW-1:0]         ne_r, ne_nxt;       // next expected; last in-order is ne - 1
  logic [IW-1:0]         laf_r, laf_nxt;     // last acceptable frame
  logic [CW-1:0]         pos_r, pos_nxt;     // scan issue pointer
  logic [IW-1:0]         chk_r, chk_nxt;     // slot whose read is in flight
  logic                  pend_r, pend_nxt;
  logic                  flush_r, flush_nxt;
  logic                  fin_r, fin_nxt;
  logic                  rej_r, rej_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [NEXT_W-1:0]     out_next_r, out_next_nxt;
  logic                  out_flush_r, out_flush_nxt;
  logic                  out_fin_r, out_fin_nxt;
  logic                  out_rej_r, out_rej_nxt;

  logic [CW-1:0]         w_c, a_c;
  logic [XW-1:0]         seq_ext;
  logic                  seq_big;
  logic                  in_rng;
  logic                  found;
  logic                  out_free;
  logic [IW+NEXT_W-1:0]  ne_wide;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic                  ram_wdata;
  logic                  ram_rdata;

  // received map: one bit per slot
  rwat_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign w_c      = clamp_f(win_r);
  assign a_c      = clamp_f(act_r);
  assign seq_ext  = XW'(seq_r);
  assign seq_big  = (seq_ext >= XW'(a_c));
  // shared compare unit for the scan: pointer inside window and active slots
  assign in_rng   = (pos_r <= CW'(laf_r)) && (pos_r < a_c);
  assign found    = pend_r && !ram_rdata;
  assign out_free = !out_valid_r || out_ready;
  assign ne_wide  = (IW+NEXT_W)'(ne_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_SLOT) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (data_r == '0 || seq_big) state_nxt = ST_DONE;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (found || !in_rng) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = (flush_r || fin_r) ? ST_CLEAR : ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_nxt       = clr_r;
    seq_nxt       = seq_r;
    data_nxt      = data_r;
    ne_nxt        = ne_r;
    laf_nxt       = laf_r;
    pos_nxt       = pos_r;
    chk_nxt       = chk_r;
    pend_nxt      = pend_r;
    flush_nxt     = flush_r;
    fin_nxt       = fin_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_next_nxt  = out_next_r;
    out_flush_nxt = out_flush_r;
    out_fin_nxt   = out_fin_r;
    out_rej_nxt   = out_rej_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + IW'(1);
      end
      ST_IDLE: begin
        seq_nxt  = in_seq_num;
        data_nxt = in_data_byte;
      end
      ST_EVAL: begin
        flush_nxt = 1'b0;
        fin_nxt   = 1'b0;
        rej_nxt   = 1'b0;
        pend_nxt  = 1'b0;
        pos_nxt   = CW'(ne_r);
        if (data_r == '0) begin
          // end of transfer: back to the start of the window
          fin_nxt = 1'b1;
          ne_nxt  = '0;
          laf_nxt = bound_f('0, w_c, a_c);
        end else if (seq_big) begin
          rej_nxt = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = seq_ext[IW-1:0];
          ram_wdata = 1'b1;
        end
      end
      ST_SCAN: begin
        if (found) begin
          ne_nxt  = chk_r;
          laf_nxt = bound_f(chk_r, w_c, a_c);
        end else if (!in_rng) begin
          // no gap in the window
          flush_nxt = 1'b1;
          ne_nxt    = '0;
          laf_nxt   = bound_f('0, w_c, a_c);
        end else begin
          chk_nxt  = pos_r[IW-1:0];
          pos_nxt  = pos_r + CW'(1);
          pend_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_next_nxt  = ne_wide[NEXT_W-1:0];
          out_flush_nxt = flush_r;
          out_fin_nxt   = fin_r;
          out_rej_nxt   = rej_r;
          clr_nxt       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      win_r       <= WINDOW_SIZE_RST;
      act_r       <= ACTIVE_SLOTS_RST;
      ne_r        <= '0;
      laf_r       <= bound_f('0, clamp_f(WINDOW_SIZE_RST), clamp_f(ACTIVE_SLOTS_RST));
      pend_r      <= 1'b0;
      flush_r     <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ne_r        <= ne_nxt;
      laf_r       <= laf_nxt;
      pend_r      <= pend_nxt;
      flush_r     <= flush_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_WINDOW_SIZE) win_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_ACTIVE_SLOTS) act_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    seq_r       <= seq_nxt;
    data_r      <= data_nxt;
    pos_r       <= pos_nxt;
    chk_r       <= chk_nxt;
    rej_r       <= rej_nxt;
    out_next_r  <= out_next_nxt;
    out_flush_r <= out_flush_nxt;
    out_fin_r   <= out_fin_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_next_seq       = out_next_r;
  assign out_window_flushed = out_flush_r;
  assign out_finished       = out_fin_r;
  assign out_seq_rejected   = out_rej_r;

  // at most one status flag per result
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_window_flushed, out_finished, out_seq_rejected}) <= 1)
    else $error("more than one status flag in a result");

  // one segment in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready high right after an accepted segment");

  // next expected never lies above the window bound
  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    ne_r <= laf_r)
    else $error("next expected beyond last acceptable frame");

  // finish and flush restart the window at zero
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_finished || out_window_flushed)) |-> out_next_seq == '0)
    else $error("window not restarted at zero");

endmodule

>>> bench/receive_window_ack_tracker_tb.sv
// Self-checking testbench for receive_window_ack_tracker: sends arrived
// segments, predicts every acknowledgement in an untimed shadow of the window.
// Depends on rwat_pkg and the tracker RTL only.
module receive_window_ack_tracker_tb;
  import rwat_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  // scan of up to SLOTS slots plus a clearing pass of SLOTS, with margin
  localparam int SETTLE_CYCLES    = 4 * SLOTS + 16;
  localparam int RANDOM_PHASES    = 12;
  localparam int RANDOM_PER_PHASE = 152;

  typedef struct packed {
    logic [NEXT_W-1:0] next_seq;
    logic              flushed;
    logic              finished;
    logic              rejected;
  } ack_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [SEQ_W-1:0]      in_seq_num   = '0;
  logic [DATA_W-1:0]     in_data_byte = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [NEXT_W-1:0]     out_next_seq;
  logic                  out_window_flushed;
  logic                  out_finished;
  logic                  out_seq_rejected;

  // Shadow of the receiver: register copies, received map and window bounds.
  // lfr is the last in-order frame (-1 at start), laf the largest acceptable.
  logic [CFG_DATA_W-1:0] win_reg = WINDOW_SIZE_RST;
  logic [CFG_DATA_W-1:0] act_reg = ACTIVE_SLOTS_RST;
  logic [SLOTS-1:0]      got_map;
  int                    lfr;
  int                    laf;
  int                    ack_seq;

  ack_t pending_acks[$];
  int   errors    = 0;
  bit   tx_calm   = 1'b0;
  bit   rx_calm   = 1'b0;
  int   tx_count  = 0;
  int   rx_count  = 0;
  int   rx_stall  = 0;

  always #5 clk = ~clk;

  receive_window_ack_tracker u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_seq_num         (in_seq_num),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_next_seq       (out_next_seq),
    .out_window_flushed (out_window_flushed),
    .out_finished       (out_finished),
    .out_seq_rejected   (out_seq_rejected)
  );

  // ---------------------------------------------------------------------------
  // Window predictor
  // ---------------------------------------------------------------------------

  // Registers are clamped to [1, SLOTS] at every use, never on write.
  function automatic int clamp_reg(logic [CFG_DATA_W-1:0] v);
    if (v < 1) return 1;
    if (v > SLOTS) return SLOTS;
    return int'(v);
  endfunction

  // Upper window bound for a given last in-order frame.
  function automatic int window_bound(int from_lfr);
    int w;
    int a;
    int top;
    w   = clamp_reg(win_reg);
    a   = clamp_reg(act_reg);
    top = from_lfr + w;
    return (top < a) ? top : a - 1;
  endfunction

  // Back to the start of a transfer; bounds taken from the live registers.
  function automatic void restart_window();
    got_map = '0;
    lfr     = -1;
    laf     = window_bound(-1);
    ack_seq = 0;
  endfunction

  // Expected acknowledgement for one accepted segment; updates the shadow.
  function automatic void predict_ack(logic [SEQ_W-1:0] seq, logic [DATA_W-1:0] data);
    ack_t want;
    int   a;
    int   pos;
    bit   full;
    a    = clamp_reg(act_reg);
    want = '0;
    full = 1'b1;
    if (data == 0) begin
      // end of transfer: all other fields zero, registers survive
      restart_window();
      want.finished = 1'b1;
    end else if (seq >= a) begin
      // out of the active slots: reported, state untouched
      want.next_seq = ack_seq[NEXT_W-1:0];
      want.rejected = 1'b1;
    end else begin
      got_map[seq] = 1'b1;
      // first gap between lfr+1 and the bound; the loop stops on it
      for (pos = lfr + 1; full && pos <= laf && pos < a && pos < SLOTS; pos++) begin
        if (pos >= 0 && !got_map[pos]) begin
          ack_seq = pos;
          lfr     = pos - 1;
          laf     = window_bound(lfr);
          full    = 1'b0;
        end
      end
      // no gap, or an empty scan range after active_slots shrank: flush
      if (full) begin
        restart_window();
        want.flushed = 1'b1;
      end
      want.next_seq = ack_seq[NEXT_W-1:0];
    end
    pending_acks.push_back(want);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One segment transaction. Valid is only lowered when a gap is drawn, so
  // back-to-back segments keep valid high across the accepting edge.
  task automatic send_segment(input logic [SEQ_W-1:0] seq, input logic [DATA_W-1:0] data);
    int gap;
    if (tx_count % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    tx_count++;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_seq_num   <= seq;
    in_data_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_ack(seq, data);
  endtask

  // Hold the sender until every acknowledgement is back, then let the
  // clearing pass finish so the block is truly idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the spare cycle keeps cfg_we from being dropped and
  // raised in one step when writes follow each other.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_WINDOW_SIZE:  win_reg = val;
      CFG_ACTIVE_SLOTS: act_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_window(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] a);
    settle();
    write_reg(CFG_WINDOW_SIZE, w);
    write_reg(CFG_ACTIVE_SLOTS, a);
  endtask

  // ---------------------------------------------------------------------------
  // Acknowledgement checker with random back-pressure
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin : ack_checker
    ack_t got;
    ack_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      got = {out_next_seq, out_window_flushed, out_finished, out_seq_rejected};
      if (pending_acks.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none actual %h", $time, got);
      end else begin
        want = pending_acks.pop_front();
        check_field("next_seq",       want.next_seq, got.next_seq);
        check_field("window_flushed", want.flushed,  got.flushed);
        check_field("finished",       want.finished, got.finished);
        check_field("seq_rejected",   want.rejected, got.rejected);
      end
      // stretches without stalls now and then
      if (rx_count % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      rx_count++;
      rx_stall = rx_calm ? 0 : $urandom_range(0, 10);
      out_ready <= (rx_stall == 0);
    end else if (!out_ready) begin
      if (rx_stall > 0) rx_stall--;
      if (rx_stall == 0) out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers (window 4, 64 slots): gaps, rejects at the field extremes,
  // a segment past the window, then end of transfer.
  task automatic test_window_basics();
    send_segment(8'd1,   8'h55);   // gap stays at 0
    send_segment(8'd0,   8'hAA);   // closes gap, next expected moves to 2
    send_segment(8'd255, 8'hFF);   // far out of range
    send_segment(8'd64,  8'h01);   // first rejected number
    send_segment(8'd63,  8'h80);   // last slot, beyond window
    send_segment(8'd7,   8'h00);   // end of transfer
  endtask

  // Smallest useful window; bounds only follow the registers after a move.
  task automatic test_tiny_window();
    set_window(7'd1, 7'd2);
    send_segment(8'd0, 8'h01);
    send_segment(8'd1, 8'h02);     // whole window in: flush
    send_segment(8'd2, 8'h03);     // rejected
  endtask

  // Shrinking active_slots under an advanced window leaves an empty scan range.
  task automatic test_shrunk_active_slots();
    set_window(7'd8, 7'd64);
    send_segment(8'd0, 8'h11);     // stale bound from last setting: flush
    send_segment(8'd0, 8'h22);
    send_segment(8'd2, 8'h33);
    send_segment(8'd1, 8'h44);     // next expected 3
    settle();
    write_reg(CFG_ACTIVE_SLOTS, 7'd2);
    send_segment(8'd0, 8'h55);     // scan start past last slot: flush
  endtask

  // Writes to indexes past the register list change nothing.
  task automatic test_spare_register_index();
    settle();
    write_reg(CFG_SPARE_A, 7'd1);
    write_reg(CFG_SPARE_B, 7'h7F);
    send_segment(8'd1, 8'h66);
    send_segment(8'd2, 8'h77);     // still rejected with 2 active slots
  endtask

  // Out-of-range register values are clamped to [1, SLOTS].
  task automatic test_clamped_registers();
    set_window(7'd0, 7'd127);
    send_segment(8'd0,  8'h99);
    send_segment(8'd1,  8'hC3);
    send_segment(8'd64, 8'h3C);
    set_window(7'd127, 7'd0);
    send_segment(8'd0, 8'hE7);
    send_segment(8'd1, 8'h18);
    send_segment(8'd0, 8'h00);
  endtask

  // Mostly in-window segments with random data, plus rejects, duplicates,
  // stray numbers and the odd end of transfer, over many register settings.
  task automatic test_random_traffic();
    int                    phase;
    int                    i;
    int                    a;
    int                    top;
    int                    pick;
    logic [CFG_DATA_W-1:0] w_val;
    logic [CFG_DATA_W-1:0] a_val;
    logic [SEQ_W-1:0]      seq;
    logic [DATA_W-1:0]     data;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       begin w_val = 7'd4;   a_val = 7'd64;  end
        1:       begin w_val = 7'd1;   a_val = 7'd1;   end
        2:       begin w_val = 7'd64;  a_val = 7'd64;  end
        3:       begin w_val = 7'd1;   a_val = 7'd64;  end
        4:       begin w_val = 7'd64;  a_val = 7'd1;   end
        5:       begin w_val = 7'd0;   a_val = 7'd0;   end
        6:       begin w_val = 7'd127; a_val = 7'd127; end
        7:       begin w_val = 7'd3;   a_val = 7'd10;  end
        8:       begin w_val = 7'd16;  a_val = 7'd40;  end
        default: begin
          w_val = CFG_DATA_W'($urandom_range(0, 127));
          a_val = CFG_DATA_W'($urandom_range(0, 127));
        end
      endcase
      set_window(w_val, a_val);
      for (i = 0; i < RANDOM_PER_PHASE; i++) begin
        a    = clamp_reg(act_reg);
        top  = (laf < a - 1) ? laf : a - 1;
        pick = $urandom_range(0, 99);
        data = DATA_W'($urandom_range(1, 255));
        if (pick < 2) begin
          seq  = SEQ_W'($urandom_range(0, 255));
          data = 8'h00;
        end else if (pick < 9) begin
          seq = SEQ_W'($urandom_range(a, 255));
        end else if (pick < 16) begin
          seq = SEQ_W'($urandom_range(0, 255));
        end else if (lfr + 1 > top) begin
          seq = SEQ_W'($urandom_range(0, a - 1));
        end else begin
          seq = SEQ_W'($urandom_range(lfr + 1, top));
        end
        // occasional full drain before the next segment
        if ($urandom_range(0, 59) == 0) settle();
        send_segment(seq, data);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    restart_window();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_window_basics();
    test_tiny_window();
    test_shrunk_active_slots();
    test_spare_register_index();
    test_clamped_registers();
    test_random_traffic();
    settle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> receive_window_ack_tracker.f
hw/rtl/rwat_pkg.sv
hw/rtl/rwat_ram.sv
hw/rtl/receive_window_ack_tracker.sv
bench/receive_window_ack_tracker_tb.sv
